/* src/rhsv_pkg.sv */
// rhsv_pkg: shared types and constants for the RGB to HSV converter.
// Holds the hue sector code and the queue status bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rhsv_pkg;

   // Sector of the largest component; red splits on whether hue wraps below zero
   typedef enum logic [1:0] {
      SECT_RED_UP   = 2'd0,
      SECT_RED_WRAP = 2'd1,
      SECT_GREEN    = 2'd2,
      SECT_BLUE     = 2'd3
   } sector_type;

   localparam int SECTOR_BITS    = 2;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

`default_nettype wire

/* src/rhsv_front.sv */
// rhsv_front: input register that classifies one pixel per beat.
// Finds max, min spread and hue sector; pushes the entry into the queue.
// Depends on rhsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhsv_front #(
   parameter int COMPONENT_BITS = 16
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              req_valid,
   output logic                                                   req_stall,
   input  wire logic [COMPONENT_BITS-1:0]                         req_red,
   input  wire logic [COMPONENT_BITS-1:0]                         req_green,
   input  wire logic [COMPONENT_BITS-1:0]                         req_blue,
   input  wire rhsv_pkg::fifo_status_type                         queue_status,
   output logic                                                   push_valid,
   output logic [5*COMPONENT_BITS+rhsv_pkg::SECTOR_BITS-1:0]      push_data
);

   localparam int N = COMPONENT_BITS;
   localparam int ENTRY_BITS = 5 * N + rhsv_pkg::SECTOR_BITS;

   logic                   valid_ff;
   logic                   valid_in;
   logic [ENTRY_BITS-1:0]  entry_ff;
   logic [ENTRY_BITS-1:0]  entry_in;
   logic                   front_ready;
   logic                   r_ge_g;
   logic                   r_ge_b;
   logic                   g_ge_b;
   logic                   g_ge_r;
   logic                   b_ge_r;
   logic                   b_ge_g;
   logic [N-1:0]           hi;
   logic [N-1:0]           lo;
   logic [N-1:0]           delta;
   rhsv_pkg::sector_type   sector;

   assign front_ready = !valid_ff || !queue_status.full;
   assign req_stall   = !front_ready;
   assign push_valid  = valid_ff;
   assign push_data   = entry_ff;

   always_comb begin
      r_ge_g = req_red >= req_green;
      r_ge_b = req_red >= req_blue;
      g_ge_b = req_green >= req_blue;
      g_ge_r = req_green >= req_red;
      b_ge_r = req_blue >= req_red;
      b_ge_g = req_blue >= req_green;

      if (r_ge_g && r_ge_b) begin
         hi     = req_red;
         sector = g_ge_b ? rhsv_pkg::SECT_RED_UP : rhsv_pkg::SECT_RED_WRAP;
      end else if (g_ge_b) begin
         hi     = req_green;
         sector = rhsv_pkg::SECT_GREEN;
      end else begin
         hi     = req_blue;
         sector = rhsv_pkg::SECT_BLUE;
      end

      if (g_ge_r && b_ge_r) begin
         lo = req_red;
      end else if (b_ge_g) begin
         lo = req_green;
      end else begin
         lo = req_blue;
      end

      delta    = hi - lo;
      entry_in = {sector, req_red, req_green, req_blue, hi, delta};
      valid_in = front_ready ? req_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (front_ready && req_valid) begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

/* src/rhsv_fifo.sv */
// rhsv_fifo: short queue between the classifier and the divider pipeline.
// Holds classified entries so each side stalls on its own.
// Depends on rhsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhsv_fifo #(
   parameter int WIDTH = 82
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push_valid,
   input  wire logic [WIDTH-1:0]             push_data,
   input  wire logic                         pop,
   output logic [WIDTH-1:0]                  pop_data,
   output rhsv_pkg::fifo_status_type         status
);

   localparam int PB = rhsv_pkg::QUEUE_PTR_BITS;

   logic [WIDTH-1:0]  mem [0:rhsv_pkg::QUEUE_DEPTH-1];
   logic [PB-1:0]     wr_ptr_ff;
   logic [PB-1:0]     wr_ptr_in;
   logic [PB-1:0]     rd_ptr_ff;
   logic [PB-1:0]     rd_ptr_in;
   logic [PB:0]       count_ff;
   logic [PB:0]       count_in;
   logic              push;

   always_comb begin
      status.full  = count_ff == (PB+1)'(rhsv_pkg::QUEUE_DEPTH);
      status.empty = count_ff == '0;
      push         = push_valid && !status.full;
      wr_ptr_in    = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
      pop_data = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* src/rhsv_back.sv */
// rhsv_back: divider pipeline producing hue and saturation, plus result register.
// One prep stage, one restoring-division stage per quotient bit, then output.
// Depends on rhsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhsv_back #(
   parameter int COMPONENT_BITS = 16
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire rhsv_pkg::fifo_status_type                         queue_status,
   input  wire logic [5*COMPONENT_BITS+rhsv_pkg::SECTOR_BITS-1:0] pop_data,
   output logic                                                   pop,
   output logic                                                   rsp_valid,
   input  wire logic                                              rsp_stall,
   output logic [COMPONENT_BITS-1:0]                              rsp_hue,
   output logic [COMPONENT_BITS-1:0]                              rsp_saturation,
   output logic [COMPONENT_BITS-1:0]                              rsp_brightness
);

   localparam int N  = COMPONENT_BITS;
   localparam int HW = N + 3;

   rhsv_pkg::sector_type sector;
   logic [N-1:0]   red;
   logic [N-1:0]   green;
   logic [N-1:0]   blue;
   logic [N-1:0]   hi;
   logic [N-1:0]   delta;
   logic [HW-1:0]  dx;
   logic [HW-1:0]  rx;
   logic [HW-1:0]  gx;
   logic [HW-1:0]  bx;
   logic [HW-1:0]  d6;
   logic [HW-1:0]  num;
   logic           enable;

   logic           vld_ff   [0:N];
   logic           vld_in   [0:N];
   logic [N-1:0]   hi_ff    [0:N];
   logic [N-1:0]   hi_in    [0:N];
   logic [HW-1:0]  d6_ff    [0:N];
   logic [HW-1:0]  d6_in    [0:N];
   logic [N-1:0]   srem_ff  [0:N];
   logic [N-1:0]   srem_in  [0:N];
   logic [HW-1:0]  hrem_ff  [0:N];
   logic [HW-1:0]  hrem_in  [0:N];
   logic [N-1:0]   sq_ff    [0:N];
   logic [N-1:0]   sq_in    [0:N];
   logic [N-1:0]   hq_ff    [0:N];
   logic [N-1:0]   hq_in    [0:N];
   logic           zero_ff  [0:N];
   logic           zero_in  [0:N];
   logic           full_ff  [0:N];
   logic           full_in  [0:N];

   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic [N-1:0]   rsp_hue_ff;
   logic [N-1:0]   rsp_hue_in;
   logic [N-1:0]   rsp_sat_ff;
   logic [N-1:0]   rsp_sat_in;
   logic [N-1:0]   rsp_bright_ff;
   logic [N-1:0]   rsp_bright_in;

   assign enable = !rsp_valid_ff || !rsp_stall;
   assign pop    = enable && !queue_status.empty;

   // prep: unpack, scale spread by six, form the hue numerator
   always_comb begin
      sector = rhsv_pkg::sector_type'(pop_data[5*N+rhsv_pkg::SECTOR_BITS-1:5*N]);
      red    = pop_data[5*N-1:4*N];
      green  = pop_data[4*N-1:3*N];
      blue   = pop_data[3*N-1:2*N];
      hi     = pop_data[2*N-1:N];
      delta  = pop_data[N-1:0];
      dx     = {3'b000, delta};
      rx     = {3'b000, red};
      gx     = {3'b000, green};
      bx     = {3'b000, blue};
      d6     = (dx << 2) + (dx << 1);
      case (sector)
         rhsv_pkg::SECT_RED_UP:   num = gx - bx;
         rhsv_pkg::SECT_RED_WRAP: num = (dx << 2) + (dx << 1) + gx - bx;
         rhsv_pkg::SECT_GREEN:    num = (dx << 1) + bx - rx;
         rhsv_pkg::SECT_BLUE:     num = (dx << 2) + rx - gx;
         default:                 num = '0;
      endcase

      vld_in[0]  = pop;
      hi_in[0]   = hi;
      d6_in[0]   = d6;
      srem_in[0] = delta;
      hrem_in[0] = num;
      sq_in[0]   = '0;
      hq_in[0]   = '0;
      zero_in[0] = delta == '0;
      full_in[0] = delta == hi;
   end

   for (genvar i = 1; i <= N; i++) begin : g_div
      logic [N:0]    s_sh;
      logic [N:0]    s_diff;
      logic          s_ge;
      logic [HW:0]   h_sh;
      logic [HW:0]   h_diff;
      logic          h_ge;

      always_comb begin
         s_sh   = {srem_ff[i-1], 1'b0};
         s_diff = s_sh - {1'b0, hi_ff[i-1]};
         s_ge   = s_sh >= {1'b0, hi_ff[i-1]};
         h_sh   = {hrem_ff[i-1], 1'b0};
         h_diff = h_sh - {1'b0, d6_ff[i-1]};
         h_ge   = h_sh >= {1'b0, d6_ff[i-1]};

         vld_in[i]  = vld_ff[i-1];
         hi_in[i]   = hi_ff[i-1];
         d6_in[i]   = d6_ff[i-1];
         srem_in[i] = s_ge ? s_diff[N-1:0] : s_sh[N-1:0];
         hrem_in[i] = h_ge ? h_diff[HW-1:0] : h_sh[HW-1:0];
         sq_in[i]   = {sq_ff[i-1][N-2:0], s_ge};
         hq_in[i]   = {hq_ff[i-1][N-2:0], h_ge};
         zero_in[i] = zero_ff[i-1];
         full_in[i] = full_ff[i-1];
      end
   end

   // output: drop quotients for grey and black, clamp full saturation
   always_comb begin
      rsp_valid_in  = enable ? vld_ff[N] : rsp_valid_ff;
      rsp_bright_in = hi_ff[N];
      rsp_hue_in    = zero_ff[N] ? '0 : hq_ff[N];
      if (zero_ff[N]) begin
         rsp_sat_in = '0;
      end else if (full_ff[N]) begin
         rsp_sat_in = '1;
      end else begin
         rsp_sat_in = sq_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= N; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (enable) begin
            vld_ff <= vld_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hi_ff         <= hi_in;
         d6_ff         <= d6_in;
         srem_ff       <= srem_in;
         hrem_ff       <= hrem_in;
         sq_ff         <= sq_in;
         hq_ff         <= hq_in;
         zero_ff       <= zero_in;
         full_ff       <= full_in;
         rsp_hue_ff    <= rsp_hue_in;
         rsp_sat_ff    <= rsp_sat_in;
         rsp_bright_ff <= rsp_bright_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_brightness = rsp_bright_ff;

`ifndef NO_ASSERTIONS
   a_black_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bright_ff == '0 |-> rsp_hue_ff == '0 && rsp_sat_ff == '0)
      else $error("black pixel gave nonzero hue or saturation");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("pop from empty queue");

   a_tail_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[N] && !enable |=> vld_ff[N])
      else $error("pipeline tail lost a beat under stall");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !vld_ff[0])
      else $error("valid survived reset");
`endif

endmodule

`default_nettype wire

/* src/rgb_to_hsv_converter.sv */
// rgb_to_hsv_converter: top level, pixel RGB in, HSV out.
// Instantiates rhsv_front, rhsv_fifo and rhsv_back; depends on rhsv_pkg.
//
//   channel   prefix   fields                               direction
//   request   req_     red, green, blue                     in
//   response  rsp_     hue, saturation, brightness          out
//
// One pixel per cycle sustained while rsp_stall stays low; the path runs through the
// front register, queue, prep stage, one divide stage per quotient bit and output.
// The restoring-division pipeline resolves one quotient bit per stage.
// Reset is synchronous and clears all valid state; the queue comes up empty.
// A response stall freezes the divider pipeline; the four-entry queue absorbs
// the front until full, then req_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter #(
   parameter int COMPONENT_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [COMPONENT_BITS-1:0]  req_red,
   input  wire logic [COMPONENT_BITS-1:0]  req_green,
   input  wire logic [COMPONENT_BITS-1:0]  req_blue,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [COMPONENT_BITS-1:0]       rsp_hue,
   output logic [COMPONENT_BITS-1:0]       rsp_saturation,
   output logic [COMPONENT_BITS-1:0]       rsp_brightness
);

   localparam int ENTRY_BITS = 5 * COMPONENT_BITS + rhsv_pkg::SECTOR_BITS;

   rhsv_pkg::fifo_status_type  queue_status;
   logic                       push_valid;
   logic [ENTRY_BITS-1:0]      push_data;
   logic                       pop;
   logic [ENTRY_BITS-1:0]      pop_data;

   rhsv_front #(
      .COMPONENT_BITS (COMPONENT_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   rhsv_fifo #(
      .WIDTH (ENTRY_BITS)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_data   (pop_data),
      .status     (queue_status)
   );

   rhsv_back #(
      .COMPONENT_BITS (COMPONENT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_status   (queue_status),
      .pop_data       (pop_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

endmodule

`default_nettype wire

/* tb/tb_rgb_to_hsv_converter.sv */
// tb_rgb_to_hsv_converter: self-checking bench for the RGB to HSV pixel converter.
// Drives pixels in random bursts, stalls the response side on its own pattern, and
// checks each HSV beat against an in-bench HSV predictor; depends on rhsv_pkg.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter;

   localparam int CB           = 16;
   localparam int HUE_SECTORS  = 6;
   localparam int GREEN_OFFSET = 2;
   localparam int BLUE_OFFSET  = 4;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 4 * CB;
   localparam logic [CB-1:0] FULL = {CB{1'b1}};

   typedef struct packed {
      logic [CB-1:0] hue;
      logic [CB-1:0] saturation;
      logic [CB-1:0] brightness;
   } hsv_pixel_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [CB-1:0] req_red;
   logic [CB-1:0] req_green;
   logic [CB-1:0] req_blue;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [CB-1:0] rsp_hue;
   logic [CB-1:0] rsp_saturation;
   logic [CB-1:0] rsp_brightness;

   hsv_pixel_type hsv_expected[$];
   int            mismatch_count = 0;
   int            idle_cycles = 0;
   int            burst_left = 0;

   rgb_to_hsv_converter #(
      .COMPONENT_BITS(CB)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hue       (rsp_hue),
      .rsp_saturation(rsp_saturation),
      .rsp_brightness(rsp_brightness)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic hsv_pixel_type predict_hsv(input logic [CB-1:0] r,
                                                 input logic [CB-1:0] g,
                                                 input logic [CB-1:0] b);
      logic [63:0]          r64, g64, b64, hi, lo, delta, num, quot;
      rhsv_pkg::sector_type sector;
      hsv_pixel_type        px;
      r64 = r;
      g64 = g;
      b64 = b;
      hi = r64;
      if (g64 > hi) hi = g64;
      if (b64 > hi) hi = b64;
      lo = r64;
      if (g64 < lo) lo = g64;
      if (b64 < lo) lo = b64;
      delta = hi - lo;
      px.hue        = '0;
      px.saturation = '0;
      px.brightness = hi[CB-1:0];
      if (hi != 0 && delta != 0) begin
         quot = (delta << CB) / hi;
         px.saturation = (quot > FULL) ? FULL : quot[CB-1:0];
         if (r64 == hi) begin
            sector = (g64 >= b64) ? rhsv_pkg::SECT_RED_UP : rhsv_pkg::SECT_RED_WRAP;
         end else if (g64 == hi) begin
            sector = rhsv_pkg::SECT_GREEN;
         end else begin
            sector = rhsv_pkg::SECT_BLUE;
         end
         case (sector)
            rhsv_pkg::SECT_RED_UP:   num = g64 - b64;
            rhsv_pkg::SECT_RED_WRAP: num = HUE_SECTORS * delta - (b64 - g64);
            rhsv_pkg::SECT_GREEN:    num = GREEN_OFFSET * delta + b64 - r64;
            default:                 num = BLUE_OFFSET * delta + r64 - g64;
         endcase
         quot = (num << CB) / (HUE_SECTORS * delta);
         px.hue = (quot > FULL) ? FULL : quot[CB-1:0];
      end
      return px;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Predict on every accepted pixel, check every accepted HSV beat.
   always @(posedge clock) begin : hsv_checker
      hsv_pixel_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (req_valid && !req_stall) begin
            hsv_expected.push_back(predict_hsv(req_red, req_green, req_blue));
         end
         if (rsp_valid && !rsp_stall) begin
            if (hsv_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected beat h=%h s=%h v=%h",
                                         rsp_hue, rsp_saturation, rsp_brightness));
            end else begin
               want = hsv_expected.pop_front();
               if (rsp_hue !== want.hue)
                  report_mismatch($sformatf("hue got %h expected %h", rsp_hue, want.hue));
               if (rsp_saturation !== want.saturation)
                  report_mismatch($sformatf("saturation got %h expected %h",
                                            rsp_saturation, want.saturation));
               if (rsp_brightness !== want.brightness)
                  report_mismatch($sformatf("brightness got %h expected %h",
                                            rsp_brightness, want.brightness));
            end
         end
      end
   end

   // Stall the response side on a duty pattern that is re-chosen now and then.
   always @(posedge clock) begin : rsp_stall_pattern
      static int hold = 0;
      static int period = 1;
      static int duty = 0;
      static int phase = 0;
      if (hold == 0) begin
         hold   = $urandom_range(40, 300);
         period = $urandom_range(2, 48);
         duty   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, period - 1);
         phase  = 0;
      end
      hold--;
      rsp_stall <= (phase < duty);
      phase = (phase + 1 >= period) ? 0 : phase + 1;
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("FAIL rgb_to_hsv_converter");
      $finish;
   end

   task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                             input logic [CB-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic test_extremes();
      send_pixel('0, '0, '0);
      send_pixel(FULL, FULL, FULL);
      send_pixel(16'h8000, 16'h8000, 16'h8000);
      send_pixel(16'h0001, 16'h0001, 16'h0001);
      send_pixel(FULL, '0, '0);
      send_pixel('0, FULL, '0);
      send_pixel('0, '0, FULL);
      send_pixel(FULL, FULL, '0);
      send_pixel('0, FULL, FULL);
      send_pixel(FULL, '0, FULL);
   endtask

   task automatic test_sectors();
      send_pixel(FULL, 16'h8000, 16'h1000);
      send_pixel(FULL, 16'h1000, 16'h8000);
      send_pixel(16'h1000, FULL, 16'h8000);
      send_pixel(16'h8000, 16'h1000, FULL);
      send_pixel(16'hC000, 16'hC000, 16'h1000);
      send_pixel(16'h1000, 16'hC000, 16'hC000);
      send_pixel(16'hC000, 16'h1000, 16'hC000);
      send_pixel(16'h1234, '0, '0);
      send_pixel(16'h0001, '0, '0);
      send_pixel(FULL, 16'hFFFE, 16'hFFFE);
      send_pixel(16'hFFFE, FULL, FULL);
      send_pixel(16'h0002, 16'h0001, 16'h0003);
   endtask

   task automatic test_random_pixels(input int count);
      repeat (count) begin
         send_pixel(CB'($urandom_range(0, FULL)), CB'($urandom_range(0, FULL)),
                    CB'($urandom_range(0, FULL)));
      end
   endtask

   // Near-grey, ties, a zero component, tiny values and single-bit values.
   task automatic test_corner_mixes(input int count);
      logic [CB-1:0] c [3];
      logic [CB-1:0] base;
      int            kind;
      repeat (count) begin
         kind = $urandom_range(0, 4);
         base = CB'($urandom_range(0, FULL));
         foreach (c[i]) c[i] = CB'($urandom_range(0, FULL));
         case (kind)
            0: begin
               base = CB'($urandom_range(0, FULL - 3));
               foreach (c[i]) c[i] = CB'(base + $urandom_range(0, 3));
            end
            1: begin
               c[$urandom_range(0, 2)] = base;
               c[$urandom_range(0, 2)] = base;
            end
            2: c[$urandom_range(0, 2)] = '0;
            3: foreach (c[i]) c[i] = CB'($urandom_range(0, 15));
            default: foreach (c[i]) c[i] = (CB'(1) << $urandom_range(0, CB - 1));
         endcase
         send_pixel(c[0], c[1], c[2]);
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_red   <= '0;
      req_green <= '0;
      req_blue  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_sectors();
      test_random_pixels(450);
      test_corner_mixes(300);
      req_valid <= 1'b0;
      while (hsv_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS rgb_to_hsv_converter");
      end else begin
         $display("FAIL rgb_to_hsv_converter");
      end
      $finish;
   end

endmodule
